// ===== hw/rtl/dpfm_pkg.sv =====
// package: shared types and constants of the pulse flow meter
`timescale 1ns / 1ps
package dpfm_pkg;
	localparam logic [1:0] CMD_PULSE  = 2'd0;
	localparam logic [1:0] CMD_ROLLUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic CFG_PPU      = 1'b0;
	localparam logic CFG_DEBOUNCE = 1'b1;

	localparam logic [63:0] FLOW_NUM  = 64'd360000000000;
	localparam logic [31:0] UNIT_MULT = 32'd1000000;
	localparam int DIV_STEPS = 64;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic        pulse_accepted;
		logic [31:0] pulses_last;
		logic [31:0] pulses_kept;
		logic [31:0] pulses_today;
		logic [31:0] flow_centi;
		logic [31:0] avg_flow_centi;
		logic [31:0] units_kept_milli;
	} out_beat_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_beat_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input beat, do simple updates
		logic div_start;  // load divider operands
		logic div_step;   // one restoring step
		logic div_sel;    // 0 units, 1 flow
		logic div_save;   // store quotient
		logic sum_clr;
		logic sum_step;
		logic avg_start;
		logic avg_save;
		logic hist_push;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_rollup;
		logic sum_last;
	} dp_stat_t;
endpackage

// ===== hw/rtl/dpfm_if.sv =====
// interfaces: valid/ready stream channel and config write channel
`timescale 1ns / 1ps
interface dpfm_in_if;
	logic valid;
	logic ready;
	dpfm_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dpfm_out_if;
	logic valid;
	logic ready;
	dpfm_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dpfm_cfg_if;
	logic valid;
	logic ready;
	dpfm_pkg::cfg_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dpfm_ctrl.sv =====
// controller: sequences one item through divider and averaging steps
`timescale 1ns / 1ps
module dpfm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_busy,
	input  dpfm_pkg::dp_stat_t stat,
	output logic               idle,
	output dpfm_pkg::dp_cmd_t  cmd
);
	import dpfm_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_UST   = 4'd2;
	localparam logic [3:0] ST_UDIV  = 4'd3;
	localparam logic [3:0] ST_FST   = 4'd4;
	localparam logic [3:0] ST_FDIV  = 4'd5;
	localparam logic [3:0] ST_PUSH  = 4'd6;
	localparam logic [3:0] ST_SUM   = 4'd7;
	localparam logic [3:0] ST_AST   = 4'd8;
	localparam logic [3:0] ST_ADIV  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [6:0] cnt_q;
	logic       cnt_last;

	assign cnt_last = (cnt_q == 7'(DIV_STEPS - 1));
	assign idle = (state_q == ST_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = in_fire;
			ST_UST: begin
				cmd.div_start = 1'b1;
			end
			ST_UDIV: begin
				cmd.div_step = 1'b1;
				cmd.div_save = cnt_last;
			end
			ST_FST: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
			end
			ST_FDIV: begin
				cmd.div_step = 1'b1;
				cmd.div_sel = 1'b1;
				cmd.div_save = cnt_last;
			end
			ST_PUSH: begin
				cmd.hist_push = 1'b1;
				cmd.sum_clr = 1'b1;
			end
			ST_SUM: cmd.sum_step = 1'b1;
			ST_AST: cmd.avg_start = 1'b1;
			ST_ADIV: begin
				cmd.div_step = 1'b1;
				cmd.avg_save = cnt_last;
			end
			ST_OUT: cmd.out_load = ~out_busy;
			default: cmd = '0;
		endcase
	end

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_DEC;
				ST_DEC: state_q <= stat.is_rollup ? ST_UST : ST_SUM;
				ST_UST: begin
					cnt_q <= '0;
					state_q <= ST_UDIV;
				end
				ST_UDIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_last) state_q <= ST_FST;
				end
				ST_FST: begin
					cnt_q <= '0;
					state_q <= ST_FDIV;
				end
				ST_FDIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_last) state_q <= ST_PUSH;
				end
				ST_PUSH: state_q <= ST_SUM;
				ST_SUM: if (stat.sum_last) state_q <= ST_AST;
				ST_AST: begin
					cnt_q <= '0;
					state_q <= ST_ADIV;
				end
				ST_ADIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_last) state_q <= ST_OUT;
				end
				ST_OUT: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/dpfm_dp.sv =====
// datapath: counters, shared restoring divider, flow history and averaging
`timescale 1ns / 1ps
module dpfm_dp #(
	parameter int AVG_DEPTH = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dpfm_pkg::in_beat_t  in_data,
	input  dpfm_pkg::cfg_beat_t cfg_data,
	input  logic                cfg_fire,
	input  dpfm_pkg::dp_cmd_t   cmd,
	output dpfm_pkg::dp_stat_t  stat,
	output dpfm_pkg::out_beat_t res
);
	import dpfm_pkg::*;

	localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FW = $clog2(AVG_DEPTH + 1);

	logic [19:0] ppu_q;
	logic [15:0] deb_q;
	logic [1:0]  cmd_q;
	logic [31:0] now_q;
	logic        acc_q;
	logic [31:0] pend_q, last_t_q, last_iv_q, rolled_q, kept_q, day_q;
	logic [31:0] units_q, flow_q, avg_q;
	logic [31:0] hist_q [AVG_DEPTH];
	logic [FW-1:0] fill_q;
	logic [PW-1:0] pos_q, sidx_q;
	logic [36:0] sum_q;
	// divider
	logic [63:0] num_q, den_q, rem_q;
	logic        zero_q;
	logic [64:0] rem_sh, rem_sub;
	logic [31:0] elapsed, ivl;
	logic [63:0] div_q;

	function automatic logic [31:0] sat32(input logic z, input logic [63:0] q);
		return (z || (q[63:32] != '0)) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	assign elapsed = in_data.now_ms - last_t_q;
	assign ivl = ((now_q - last_t_q) < last_iv_q) ? last_iv_q : (now_q - last_t_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppu_q <= 20'd1000;
			deb_q <= 16'd50;
		end else if (cfg_fire) begin
			if (cfg_data.index == {1'b0, CFG_PPU}) ppu_q <= cfg_data.data[19:0];
			else if (cfg_data.index == {1'b0, CFG_DEBOUNCE}) deb_q <= cfg_data.data[15:0];
		end
	end

	// restoring divide step
	assign rem_sh = {rem_q, num_q[63]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			div_q <= '0;
			if (!cmd.div_sel) begin
				num_q <= 64'(kept_q) * 64'(UNIT_MULT);
				den_q <= 64'(ppu_q);
				zero_q <= (ppu_q == '0);
			end else begin
				num_q <= FLOW_NUM;
				den_q <= 64'(ivl) * 64'(ppu_q);
				zero_q <= (ivl == '0) || (ppu_q == '0);
			end
		end else if (cmd.avg_start) begin
			rem_q <= '0;
			div_q <= '0;
			num_q <= 64'(sum_q);
			den_q <= 64'(fill_q);
			zero_q <= (fill_q == '0);
		end else if (cmd.div_step) begin
			num_q <= {num_q[62:0], 1'b0};
			if (!rem_sub[64]) begin
				rem_q <= rem_sub[63:0];
				div_q <= {div_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				div_q <= {div_q[62:0], 1'b0};
			end
		end
	end

	// main state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0; now_q <= '0; acc_q <= 1'b0;
			pend_q <= '0; last_t_q <= '0; last_iv_q <= '0;
			rolled_q <= '0; kept_q <= '0; day_q <= '0;
			units_q <= '0; flow_q <= '0; avg_q <= '0;
			fill_q <= '0; pos_q <= '0;
		end else begin
			if (cmd.load) begin
				cmd_q <= in_data.cmd;
				now_q <= in_data.now_ms;
				acc_q <= 1'b0;
				case (in_data.cmd)
					CMD_PULSE: if (elapsed >= 32'(deb_q)) begin
						pend_q <= pend_q + 32'd1;
						last_iv_q <= elapsed;
						last_t_q <= in_data.now_ms;
						acc_q <= 1'b1;
					end
					CMD_ROLLUP: begin
						rolled_q <= pend_q;
						pend_q <= '0;
						kept_q <= kept_q + pend_q;
						day_q <= day_q + pend_q;
					end
					CMD_CLEAR: kept_q <= '0;
					default: ;
				endcase
			end
			if (cmd.div_save) begin
				// the divider uses the next-step quotient, last bit arrives now
				if (!cmd.div_sel) units_q <= sat32(zero_q, {div_q[62:0], ~rem_sub[64]});
				else flow_q <= (ivl == '0) ? 32'd0 :
					sat32(zero_q, {div_q[62:0], ~rem_sub[64]});
			end
			if (cmd.hist_push) begin
				pos_q <= (pos_q == PW'(AVG_DEPTH - 1)) ? '0 : pos_q + PW'(1);
				if (fill_q != FW'(AVG_DEPTH)) fill_q <= fill_q + FW'(1);
			end
			if (cmd.avg_save) avg_q <= zero_q ? 32'd0 : {div_q[30:0], ~rem_sub[64]};
		end
	end

	// history store, one entry per rollup
	always_ff @(posedge clk) begin
		if (cmd.hist_push) hist_q[pos_q] <= flow_q;
	end

	// sum of filled entries, one per cycle
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0;
			sidx_q <= '0;
		end else if (cmd.sum_step) begin
			if (FW'(sidx_q) < fill_q) sum_q <= sum_q + 37'(hist_q[sidx_q]);
			if (sidx_q != PW'(AVG_DEPTH - 1)) sidx_q <= sidx_q + PW'(1);
		end else if (cmd.load) begin
			sum_q <= '0;
			sidx_q <= '0;
		end
	end

	assign stat.is_rollup = (cmd_q == CMD_ROLLUP);
	assign stat.sum_last = (sidx_q == PW'(AVG_DEPTH - 1));

	assign res.pulse_accepted = acc_q;
	assign res.pulses_last = rolled_q;
	assign res.pulses_kept = kept_q;
	assign res.pulses_today = day_q;
	assign res.flow_centi = flow_q;
	assign res.avg_flow_centi = avg_q;
	assign res.units_kept_milli = units_q;
endmodule

// ===== hw/rtl/debounced_pulse_flow_meter.sv =====
// top level: pulse flow meter with debounce and moving average
// one item at a time: the next beat is taken only once the last result is in the output register
// (64-step restoring divider: two divides for a rollup, one for the average on every item)
// reset: arst_n clears all counters, history fill and the controller;
// ppu_milli returns to 1000 and debounce_ms to 50
`timescale 1ns / 1ps
module debounced_pulse_flow_meter #(
	parameter int AVG_DEPTH = 5
) (
	input logic       clk,
	input logic       arst_n,
	dpfm_in_if.sink   in_ch,
	dpfm_out_if.source out_ch,
	dpfm_cfg_if.sink  cfg
);
	import dpfm_pkg::*;

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	out_beat_t res;
	logic      idle, in_fire, out_v_q;
	out_beat_t out_q;

	assign in_ch.ready = idle;
	assign in_fire = in_ch.valid & in_ch.ready;
	assign cfg.ready = 1'b1;

	dpfm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_v_q & ~out_ch.ready), .stat(stat), .idle(idle), .cmd(cmd)
	);

	dpfm_dp #(.AVG_DEPTH(AVG_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_ch.data), .cfg_data(cfg.data),
		.cfg_fire(cfg.valid), .cmd(cmd), .stat(stat), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (cmd.out_load) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= res;
	end
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q && $stable(out_q))
		else $error("result dropped under stall");
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready)
		else $error("took a beat while busy");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> idle)
		else $error("load outside idle");
`endif
endmodule

// ===== verif/tb_debounced_pulse_flow_meter.sv =====
// testbench: directed and random checking of the pulse flow meter against a local predictor
`timescale 1ns / 1ps
module tb_debounced_pulse_flow_meter;
	import dpfm_pkg::*;

	localparam int HIST_DEPTH = 5;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	dpfm_in_if in_ch ();
	dpfm_out_if out_ch ();
	dpfm_cfg_if cfg ();

	debounced_pulse_flow_meter #(.AVG_DEPTH(HIST_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	// predictor state
	logic [19:0] m_ppu;
	logic [15:0] m_debounce;
	logic [31:0] m_pending, m_last_time, m_last_ivl, m_rolled, m_kept, m_day;
	logic [31:0] m_units, m_flow;
	logic [31:0] m_hist [HIST_DEPTH];
	int m_fill, m_pos;

	out_beat_t meter_expect_q[$];
	int fail_count;
	int idle_cycles;
	bit rx_stall_en;
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] sat_quot(logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		if (den == 64'd0)
			return 32'hFFFF_FFFF;
		q = num / den;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// advance the meter model by one beat and queue its result
	function automatic void meter_predict(in_beat_t b);
		out_beat_t r;
		logic [31:0] elapsed, ivl;
		logic [63:0] sum;
		r = '0;
		elapsed = b.now_ms - m_last_time;
		case (b.cmd)
			CMD_PULSE: begin
				if (elapsed >= {16'd0, m_debounce}) begin
					m_pending = m_pending + 1;
					m_last_ivl = elapsed;
					m_last_time = b.now_ms;
					r.pulse_accepted = 1'b1;
				end
			end
			CMD_ROLLUP: begin
				m_rolled = m_pending;
				m_pending = '0;
				m_kept = m_kept + m_rolled;
				m_day = m_day + m_rolled;
				m_units = sat_quot({32'd0, m_kept} * 64'd1000000, {44'd0, m_ppu});
				ivl = (elapsed < m_last_ivl) ? m_last_ivl : elapsed;
				m_flow = (ivl == 0) ? 32'd0 : sat_quot(FLOW_NUM, {32'd0, ivl} * {44'd0, m_ppu});
				m_hist[m_pos] = m_flow;
				m_pos = (m_pos + 1) % HIST_DEPTH;
				if (m_fill < HIST_DEPTH)
					m_fill++;
			end
			CMD_CLEAR: m_kept = '0;
			default: ;
		endcase
		sum = '0;
		for (int i = 0; i < m_fill; i++)
			sum += m_hist[i];
		r.pulses_last = m_rolled;
		r.pulses_kept = m_kept;
		r.pulses_today = m_day;
		r.flow_centi = m_flow;
		r.avg_flow_centi = (m_fill == 0) ? 32'd0 : 32'(sum / m_fill);
		r.units_kept_milli = m_units;
		meter_expect_q.push_back(r);
	endfunction

	// send one input beat, with random idle before it when may_idle is set
	task automatic send_beat(logic [1:0] cmd, logic [31:0] now_ms, bit may_idle = 1);
		in_beat_t b;
		b.cmd = cmd;
		b.now_ms = now_ms;
		while (may_idle && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		do @(posedge clk); while (!in_ch.ready);
		meter_predict(b);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (meter_expect_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_beat_t c;
		c.index = idx;
		c.data = value;
		wait_drain();
		cfg.valid <= 1'b1;
		cfg.data <= c;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == 2'(CFG_PPU))
			m_ppu = value[19:0];
		else if (idx == 2'(CFG_DEBOUNCE))
			m_debounce = value[15:0];
	endtask

	// result checker
	always @(posedge clk) begin
		out_beat_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			idle_cycles <= 0;
			got = out_ch.data;
			if (meter_expect_q.size() == 0) begin
				$error("unexpected result beat");
				fail_count++;
			end else begin
				want = meter_expect_q.pop_front();
				if (got.pulse_accepted !== want.pulse_accepted) begin
					$error("pulse_accepted exp %0d got %0d", want.pulse_accepted, got.pulse_accepted);
					fail_count++;
				end
				if (got.pulses_last !== want.pulses_last) begin
					$error("pulses_last exp %0d got %0d", want.pulses_last, got.pulses_last);
					fail_count++;
				end
				if (got.pulses_kept !== want.pulses_kept) begin
					$error("pulses_kept exp %0d got %0d", want.pulses_kept, got.pulses_kept);
					fail_count++;
				end
				if (got.pulses_today !== want.pulses_today) begin
					$error("pulses_today exp %0d got %0d", want.pulses_today, got.pulses_today);
					fail_count++;
				end
				if (got.flow_centi !== want.flow_centi) begin
					$error("flow_centi exp %0d got %0d", want.flow_centi, got.flow_centi);
					fail_count++;
				end
				if (got.avg_flow_centi !== want.avg_flow_centi) begin
					$error("avg_flow_centi exp %0d got %0d", want.avg_flow_centi,
						got.avg_flow_centi);
					fail_count++;
				end
				if (got.units_kept_milli !== want.units_kept_milli) begin
					$error("units_kept_milli exp %0d got %0d", want.units_kept_milli,
						got.units_kept_milli);
					fail_count++;
				end
			end
		end else if (in_ch.valid && in_ch.ready) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver stall
	always @(posedge clk)
		out_ch.ready <= rx_stall_en ? ($urandom_range(99) >= 6) : 1'b1;

	// watchdog
	always @(posedge clk)
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end

	// extremes of time, commands and the unused code
	task automatic test_directed();
		send_beat(CMD_ROLLUP, 32'd0);
		send_beat(CMD_PULSE, 32'd10);
		send_beat(CMD_PULSE, 32'd60);
		send_beat(CMD_PULSE, 32'd100);
		send_beat(CMD_PULSE, 32'd200);
		send_beat(2'd3, 32'hFFFF_FFFF);
		send_beat(CMD_ROLLUP, 32'd300);
		send_beat(CMD_ROLLUP, 32'd300);
		send_beat(CMD_CLEAR, 32'hAAAA_5555);
		send_beat(CMD_ROLLUP, 32'h5555_AAAA);
		send_beat(CMD_PULSE, 32'hFFFF_FFF0);
		send_beat(CMD_PULSE, 32'd40);
		send_beat(CMD_ROLLUP, 32'd41);
		send_beat(CMD_PULSE, 32'hFFFF_FFFF);
		send_beat(CMD_ROLLUP, 32'hFFFF_FFFF);
		send_beat(CMD_ROLLUP, 32'd7);
	endtask

	// register extremes, including zero ppu and zero debounce
	task automatic test_config_extremes();
		write_reg(CFG_DEBOUNCE, 32'd0);
		write_reg(CFG_PPU, 32'd1);
		send_beat(CMD_PULSE, clock_ms);
		send_beat(CMD_PULSE, clock_ms);
		send_beat(CMD_ROLLUP, clock_ms);
		send_beat(CMD_PULSE, clock_ms + 1);
		send_beat(CMD_ROLLUP, clock_ms + 1);
		write_reg(CFG_PPU, 32'd0);
		send_beat(CMD_ROLLUP, clock_ms + 9);
		write_reg(CFG_PPU, 32'd1000000);
		write_reg(CFG_DEBOUNCE, 32'd65535);
		send_beat(CMD_PULSE, clock_ms + 65534);
		send_beat(CMD_PULSE, clock_ms + 65536);
		send_beat(CMD_ROLLUP, clock_ms + 70000);
		write_reg(CFG_PPU, 32'hFFFFF);
		send_beat(CMD_ROLLUP, clock_ms + 70001);
	endtask

	// mostly time-ordered pulse trains with random rollups, clears and unused codes
	task automatic test_random(int n_items, int ppu, int deb, bit hold_off);
		logic [31:0] t;
		int r;
		write_reg(CFG_PPU, ppu);
		write_reg(CFG_DEBOUNCE, deb);
		t = $urandom;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 5)
				t = $urandom;
			else
				t = t + $urandom_range(deb + deb / 2 + 2);
			if (r < 60)
				send_beat(CMD_PULSE, t, !hold_off);
			else if (r < 85)
				send_beat(CMD_ROLLUP, t, !hold_off);
			else if (r < 93)
				send_beat(CMD_CLEAR, t, !hold_off);
			else
				send_beat(2'd3, t, !hold_off);
			if (i % 97 == 50)
				wait_drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		fail_count = 0;
		idle_cycles = 0;
		rx_stall_en = 1'b1;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		out_ch.ready = 1'b0;
		clock_ms = 32'd1000;
		m_ppu = 20'd1000;
		m_debounce = 16'd50;
		{m_pending, m_last_time, m_last_ivl, m_rolled, m_kept, m_day, m_units, m_flow} = '0;
		m_fill = 0;
		m_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_random(300, 1000, 50, 0);
		test_random(300, $urandom_range(1, 1000000), $urandom_range(0, 65535), 0);
		rx_stall_en = 1'b0;
		test_random(200, 1, 0, 1);
		rx_stall_en = 1'b1;
		test_random(400, $urandom_range(1, 5000), $urandom_range(0, 200), 0);

		wait_drain();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
